### rtl/mtq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtq_pkg
// Shared widths, types and the output saturation function for the
// rotation matrix to quaternion pipeline.
// ----------------------------------------------------------------------------
package mtq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int M_W       = 16;
    localparam int Q_W       = 16;
    localparam int LANES     = 3;
    // sums and differences of two matrix elements
    localparam int NM_W      = M_W + 1;
    // positive root argument, and its signed form
    localparam int AM_W      = ((M_W > FRAC_BITS) ? M_W : FRAC_BITS) + 2;
    localparam int AG_W      = AM_W + 1;
    localparam int SQIN_W    = AM_W + FRAC_BITS;
    localparam int SQ_W      = SQIN_W + (SQIN_W % 2);
    localparam int RT_W      = SQ_W / 2;
    localparam int DEN_W     = RT_W + 1;
    localparam int NUM_W     = NM_W + FRAC_BITS;
    localparam int XW        = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;
    localparam int MW        = (RT_W > Q_W) ? RT_W : Q_W;

    // component that carries the root term
    typedef enum logic [1:0] {
        ROOT_W = 2'd0,
        ROOT_X = 2'd1,
        ROOT_Y = 2'd2,
        ROOT_Z = 2'd3
    } t_root;

    typedef struct packed {
        t_root                        root;
        logic                         bad;
        logic [LANES-1:0]             neg;
        logic [LANES-1:0][NM_W-1:0]   mag;
        logic [RT_W-1:0]              rmag;
    } t_side;

    typedef struct packed {
        logic [Q_W-1:0] val;
        logic           flag;
    } t_sat;

    function automatic t_sat sat_q(input logic [MW-1:0] mag, input logic ovf,
                                   input logic neg);
        t_sat s;
        logic big;
        if (neg) begin
            big = ovf || (mag > MW'(2**(Q_W-1)));
        end else begin
            big = ovf || (mag > MW'(2**(Q_W-1) - 1));
        end
        s.flag = big;
        if (big) begin
            s.val = neg ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        end else begin
            s.val = neg ? (~mag[Q_W-1:0] + 1'b1) : mag[Q_W-1:0];
        end
        return s;
    endfunction

endpackage

### rtl/mtq_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtq_sqrt
// Pipelined integer square root, one result bit per stage, of the root
// argument scaled by the fraction bits. Side data travels with each item.
// ----------------------------------------------------------------------------
module mtq_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic [mtq_pkg::AM_W-1:0] i_arg,
    input  mtq_pkg::t_side          i_side,
    output logic                    o_valid,
    output logic [mtq_pkg::RT_W-1:0] o_root,
    output mtq_pkg::t_side          o_side
);

    localparam int STG  = mtq_pkg::RT_W;
    localparam int SQ_W = mtq_pkg::SQ_W;

    logic                r_v    [STG];
    logic [SQ_W-1:0]     r_n    [STG];
    logic [SQ_W-1:0]     r_res  [STG];
    mtq_pkg::t_side      r_side [STG];

    for (genvar g = 0; g < STG; g++) begin : g_stage
        localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2*g);
        logic            w_v_in;
        logic [SQ_W-1:0] w_n_in;
        logic [SQ_W-1:0] w_res_in;
        mtq_pkg::t_side  w_side_in;
        logic [SQ_W-1:0] w_t;
        logic [SQ_W-1:0] n_n;
        logic [SQ_W-1:0] n_res;

        if (g == 0) begin : g_first
            assign w_v_in    = i_valid;
            assign w_n_in    = SQ_W'({i_arg, {mtq_pkg::FRAC_BITS{1'b0}}});
            assign w_res_in  = '0;
            assign w_side_in = i_side;
        end else begin : g_next
            assign w_v_in    = r_v[g-1];
            assign w_n_in    = r_n[g-1];
            assign w_res_in  = r_res[g-1];
            assign w_side_in = r_side[g-1];
        end

        assign w_t = w_res_in + BIT;

        always_comb begin
            if (w_n_in >= w_t) begin
                n_n   = w_n_in - w_t;
                n_res = (w_res_in >> 1) + BIT;
            end else begin
                n_n   = w_n_in;
                n_res = w_res_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= w_v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[g]    <= n_n;
                r_res[g]  <= n_res;
                r_side[g] <= w_side_in;
            end
        end
    end

    assign o_valid = r_v[STG-1];
    assign o_root  = r_res[STG-1][mtq_pkg::RT_W-1:0];
    assign o_side  = r_side[STG-1];

endmodule

### rtl/mtq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtq_div
// Three-lane pipelined restoring divider sharing one divisor. The first
// stage flags quotients past the result width, then one quotient bit per
// stage.
// ----------------------------------------------------------------------------
module mtq_div (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_en,
    input  logic                                         i_valid,
    input  logic [mtq_pkg::DEN_W-1:0]                    i_den,
    input  logic [mtq_pkg::LANES-1:0][mtq_pkg::NUM_W-1:0] i_num,
    input  mtq_pkg::t_side                               i_side,
    output logic                                         o_valid,
    output logic [mtq_pkg::LANES-1:0][mtq_pkg::Q_W-1:0]  o_quo,
    output logic [mtq_pkg::LANES-1:0]                    o_ovf,
    output mtq_pkg::t_side                               o_side
);

    localparam int DS    = mtq_pkg::Q_W + 1;
    localparam int LANES = mtq_pkg::LANES;
    localparam int NUM_W = mtq_pkg::NUM_W;
    localparam int Q_W   = mtq_pkg::Q_W;
    localparam int XW    = mtq_pkg::XW;

    logic                               r_v    [DS];
    logic [mtq_pkg::DEN_W-1:0]          r_den  [DS];
    logic [LANES-1:0][NUM_W-1:0]        r_rem  [DS];
    logic [LANES-1:0][Q_W-1:0]          r_q    [DS];
    logic [LANES-1:0]                   r_ovf  [DS];
    mtq_pkg::t_side                     r_side [DS];

    // stage 0: quotient overflow check
    logic [LANES-1:0] n_ovf;
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_ovf[l] = XW'(i_num[l]) >= (XW'(i_den) << Q_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_den[0]  <= i_den;
            r_rem[0]  <= i_num;
            r_q[0]    <= '0;
            r_ovf[0]  <= n_ovf;
            r_side[0] <= i_side;
        end
    end

    for (genvar g = 1; g < DS; g++) begin : g_stage
        logic [LANES-1:0][NUM_W-1:0] n_rem;
        logic [LANES-1:0][Q_W-1:0]   n_q;
        logic [XW-1:0]               w_sub;

        assign w_sub = XW'(r_den[g-1]) << (Q_W - g);

        always_comb begin
            for (int l = 0; l < LANES; l++) begin
                if (XW'(r_rem[g-1][l]) >= w_sub) begin
                    n_rem[l] = r_rem[g-1][l] - w_sub[NUM_W-1:0];
                    n_q[l]   = {r_q[g-1][l][Q_W-2:0], 1'b1};
                end else begin
                    n_rem[l] = r_rem[g-1][l];
                    n_q[l]   = {r_q[g-1][l][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= r_v[g-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[g]  <= r_den[g-1];
                r_rem[g]  <= n_rem;
                r_q[g]    <= n_q;
                r_ovf[g]  <= r_ovf[g-1];
                r_side[g] <= r_side[g-1];
            end
        end
    end

    assign o_valid = r_v[DS-1];
    assign o_quo   = r_q[DS-1];
    assign o_ovf   = r_ovf[DS-1];
    assign o_side  = r_side[DS-1];

endmodule

### rtl/matrix_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_to_quaternion
// Rotation matrix (Q2.14) to unit quaternion by the trace / largest
// diagonal method, with saturation and a bad input flag.
//
//   channel | valid   | ready   | payload
//   --------+---------+---------+-----------------------------------
//   input   | i_valid | o_ready | i_m00 .. i_m22
//   output  | o_valid | i_ready | o_qw, o_qx, o_qy, o_qz, o_bad_input
//
// One item enters per cycle while o_ready is high. The pipeline holds two
// setup stages, one square root stage per root bit, the divider setup stage,
// one divider stage per quotient bit plus one, and the output register.
// Reset clears all valid bits; data registers are not reset.
// The pipeline advances as a whole; it keeps moving while a result waits
// unless the last divider stage holds an item, so no item is lost.
// ----------------------------------------------------------------------------
module matrix_to_quaternion (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_m00,
    input  logic signed [15:0] i_m01,
    input  logic signed [15:0] i_m02,
    input  logic signed [15:0] i_m10,
    input  logic signed [15:0] i_m11,
    input  logic signed [15:0] i_m12,
    input  logic signed [15:0] i_m20,
    input  logic signed [15:0] i_m21,
    input  logic signed [15:0] i_m22,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_qw,
    output logic signed [15:0] o_qx,
    output logic signed [15:0] o_qy,
    output logic signed [15:0] o_qz,
    output logic               o_bad_input
);

    localparam int AG_W  = mtq_pkg::AG_W;
    localparam int NM_W  = mtq_pkg::NM_W;
    localparam int LANES = mtq_pkg::LANES;
    localparam logic signed [AG_W-1:0] ONE = AG_W'(1) << mtq_pkg::FRAC_BITS;

    logic w_en;

    // ------------------------------------------------------------------ S1
    logic signed [AG_W-1:0] w_e00, w_e11, w_e22, w_trace, w_mii;
    logic signed [NM_W-1:0] n_d0, n_d1, n_d2, n_s0, n_s1, n_s2;
    logic                   w_sel1, w_sel2;
    mtq_pkg::t_root         n1_idx;

    assign w_e00   = AG_W'(i_m00);
    assign w_e11   = AG_W'(i_m11);
    assign w_e22   = AG_W'(i_m22);
    assign w_trace = w_e00 + w_e11 + w_e22;
    assign w_sel1  = w_e11 > w_e00;
    assign w_mii   = w_sel1 ? w_e11 : w_e00;
    assign w_sel2  = w_e22 > w_mii;
    assign n1_idx  = w_sel2 ? mtq_pkg::ROOT_Z : (w_sel1 ? mtq_pkg::ROOT_Y : mtq_pkg::ROOT_X);

    assign n_d0 = NM_W'(i_m21) - NM_W'(i_m12);
    assign n_d1 = NM_W'(i_m02) - NM_W'(i_m20);
    assign n_d2 = NM_W'(i_m10) - NM_W'(i_m01);
    assign n_s0 = NM_W'(i_m21) + NM_W'(i_m12);
    assign n_s1 = NM_W'(i_m02) + NM_W'(i_m20);
    assign n_s2 = NM_W'(i_m10) + NM_W'(i_m01);

    logic                   r1_v;
    logic                   r1_tpos;
    mtq_pkg::t_root         r1_idx;
    logic signed [AG_W-1:0] r1_argt, r1_arg0, r1_arg1, r1_arg2;
    logic signed [NM_W-1:0] r1_d0, r1_d1, r1_d2, r1_s0, r1_s1, r1_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_tpos <= w_trace > 0;
            r1_idx  <= n1_idx;
            r1_argt <= w_trace + ONE;
            r1_arg0 <= w_e00 - w_e11 - w_e22 + ONE;
            r1_arg1 <= w_e11 - w_e22 - w_e00 + ONE;
            r1_arg2 <= w_e22 - w_e00 - w_e11 + ONE;
            r1_d0   <= n_d0;
            r1_d1   <= n_d1;
            r1_d2   <= n_d2;
            r1_s0   <= n_s0;
            r1_s1   <= n_s1;
            r1_s2   <= n_s2;
        end
    end

    // ------------------------------------------------------------------ S2
    logic signed [AG_W-1:0]      w_arg;
    logic [LANES-1:0]            w_negf;
    logic [LANES-1:0][NM_W-1:0]  w_nums;
    mtq_pkg::t_side              n2_side;

    always_comb begin
        n2_side      = '0;
        w_arg        = r1_argt;
        w_negf       = 3'b111;
        w_nums       = {r1_d2, r1_d1, r1_d0};
        n2_side.root = mtq_pkg::ROOT_W;
        if (!r1_tpos) begin
            n2_side.root = r1_idx;
            // the lane that feeds w keeps its sign
            w_negf       = 3'b110;
            case (r1_idx)
                mtq_pkg::ROOT_X: begin
                    w_arg  = r1_arg0;
                    w_nums = {r1_s1, r1_s2, r1_d0};
                end
                mtq_pkg::ROOT_Y: begin
                    w_arg  = r1_arg1;
                    w_nums = {r1_s2, r1_s0, r1_d1};
                end
                mtq_pkg::ROOT_Z: begin
                    w_arg  = r1_arg2;
                    w_nums = {r1_s0, r1_s1, r1_d2};
                end
                default: begin
                    w_arg  = r1_arg0;
                    w_nums = {r1_s1, r1_s2, r1_d0};
                end
            endcase
        end
        n2_side.bad = w_arg <= 0;
        for (int l = 0; l < LANES; l++) begin
            n2_side.neg[l] = w_nums[l][NM_W-1] ^ w_negf[l];
            n2_side.mag[l] = w_nums[l][NM_W-1] ? (~w_nums[l] + 1'b1) : w_nums[l];
        end
    end

    logic                        r2_v;
    logic [mtq_pkg::AM_W-1:0]    r2_arg;
    mtq_pkg::t_side              r2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_arg  <= w_arg[mtq_pkg::AM_W-1:0];
            r2_side <= n2_side;
        end
    end

    // ----------------------------------------------------------- square root
    logic                      w_sq_v;
    logic [mtq_pkg::RT_W-1:0]  w_root;
    mtq_pkg::t_side            w_sq_side;

    mtq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r2_v),
        .i_arg   (r2_arg),
        .i_side  (r2_side),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_side  (w_sq_side)
    );

    // ------------------------------------------------------------------ S3
    logic                                         r3_v;
    logic [mtq_pkg::DEN_W-1:0]                    r3_den;
    logic [LANES-1:0][mtq_pkg::NUM_W-1:0]         r3_num;
    mtq_pkg::t_side                               r3_side;
    logic [mtq_pkg::RT_W:0]                       w_rinc;
    mtq_pkg::t_side                               n3_side;
    logic [LANES-1:0][mtq_pkg::NUM_W-1:0]         n3_num;

    assign w_rinc = {1'b0, w_root} + 1'b1;

    always_comb begin
        n3_side      = w_sq_side;
        n3_side.rmag = w_rinc[mtq_pkg::RT_W:1];
        for (int l = 0; l < LANES; l++) begin
            // round to nearest: add half the divisor, which is the root
            n3_num[l] = (mtq_pkg::NUM_W'(w_sq_side.mag[l]) << mtq_pkg::FRAC_BITS)
                      + mtq_pkg::NUM_W'(w_root);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_den  <= {w_root, 1'b0};
            r3_num  <= n3_num;
            r3_side <= n3_side;
        end
    end

    // --------------------------------------------------------------- divider
    logic                                      w_dv;
    logic [LANES-1:0][mtq_pkg::Q_W-1:0]        w_quo;
    logic [LANES-1:0]                          w_ovf;
    mtq_pkg::t_side                            w_dside;

    mtq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r3_v),
        .i_den   (r3_den),
        .i_num   (r3_num),
        .i_side  (r3_side),
        .o_valid (w_dv),
        .o_quo   (w_quo),
        .o_ovf   (w_ovf),
        .o_side  (w_dside)
    );

    // ---------------------------------------------------------- output stage
    mtq_pkg::t_sat             w_ls [LANES];
    mtq_pkg::t_sat             w_rs;
    logic [15:0]               n_qw, n_qx, n_qy, n_qz;
    logic                      n_bad;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            w_ls[l] = mtq_pkg::sat_q(mtq_pkg::MW'(w_quo[l]), w_ovf[l], w_dside.neg[l]);
        end
        w_rs = mtq_pkg::sat_q(mtq_pkg::MW'(w_dside.rmag), 1'b0,
                              w_dside.root != mtq_pkg::ROOT_W);
        case (w_dside.root)
            mtq_pkg::ROOT_W: begin
                n_qw = w_rs.val;     n_qx = w_ls[0].val;
                n_qy = w_ls[1].val;  n_qz = w_ls[2].val;
            end
            mtq_pkg::ROOT_X: begin
                n_qw = w_ls[0].val;  n_qx = w_rs.val;
                n_qy = w_ls[1].val;  n_qz = w_ls[2].val;
            end
            mtq_pkg::ROOT_Y: begin
                n_qw = w_ls[0].val;  n_qy = w_rs.val;
                n_qz = w_ls[1].val;  n_qx = w_ls[2].val;
            end
            mtq_pkg::ROOT_Z: begin
                n_qw = w_ls[0].val;  n_qz = w_rs.val;
                n_qx = w_ls[1].val;  n_qy = w_ls[2].val;
            end
            default: begin
                n_qw = w_rs.val;     n_qx = w_ls[0].val;
                n_qy = w_ls[1].val;  n_qz = w_ls[2].val;
            end
        endcase
        n_bad = w_rs.flag | w_ls[0].flag | w_ls[1].flag | w_ls[2].flag;
        // root argument not positive: drop all components
        if (w_dside.bad) begin
            n_qw  = '0;
            n_qx  = '0;
            n_qy  = '0;
            n_qz  = '0;
            n_bad = 1'b1;
        end
    end

    logic        r_out_v;
    logic [15:0] r_qw, r_qx, r_qy, r_qz;
    logic        r_bad;

    // hold the pipeline only when a result waits and another is ready behind it
    assign w_en    = !r_out_v || i_ready || !w_dv;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en && w_dv) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && w_dv) begin
            r_qw  <= n_qw;
            r_qx  <= n_qx;
            r_qy  <= n_qy;
            r_qz  <= n_qz;
            r_bad <= n_bad;
        end
    end

    assign o_valid     = r_out_v;
    assign o_qw        = r_qw;
    assign o_qx        = r_qx;
    assign o_qy        = r_qy;
    assign o_qz        = r_qz;
    assign o_bad_input = r_bad;

    // ------------------------------------------------------------ assertions
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && w_dv))
        else $error("input stalled without a waiting result");

    a_trace_never_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_v && r2_side.root == mtq_pkg::ROOT_W) |-> !r2_side.bad)
        else $error("positive trace flagged bad");

    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_sq_v && !w_sq_side.bad) |-> (w_root != '0))
        else $error("zero root for positive argument");

endmodule
